// ===== rtl/cam_pkg.sv =====
`default_nettype none
package cam_pkg;

  localparam int CordicIters = 16;
  localparam int IterW = 5;

  localparam logic signed [17:0] PitchLimit = 18'sd22784;
  localparam logic signed [18:0] YawHalf = 19'sd46080;
  localparam logic signed [18:0] QuarterTurn = 19'sd23040;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

  // atan(2^-i) in 2^-16 degree.
  function automatic logic signed [27:0] atan_lookup(input logic [IterW-1:0] i);
    logic signed [27:0] v;
    unique case (i)
      5'd0:  v = 28'sd2949120;
      5'd1:  v = 28'sd1740967;
      5'd2:  v = 28'sd919879;
      5'd3:  v = 28'sd466945;
      5'd4:  v = 28'sd234379;
      5'd5:  v = 28'sd117304;
      5'd6:  v = 28'sd58666;
      5'd7:  v = 28'sd29335;
      5'd8:  v = 28'sd14668;
      5'd9:  v = 28'sd7334;
      5'd10: v = 28'sd3667;
      5'd11: v = 28'sd1833;
      5'd12: v = 28'sd917;
      5'd13: v = 28'sd458;
      5'd14: v = 28'sd229;
      5'd15: v = 28'sd115;
      5'd16: v = 28'sd57;
      5'd17: v = 28'sd29;
      5'd18: v = 28'sd14;
      5'd19: v = 28'sd7;
      5'd20: v = 28'sd4;
      5'd21: v = 28'sd2;
      5'd22: v = 28'sd1;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

  // Saturate to +-16384.
  function automatic logic signed [15:0] sat14(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd16384) r = 16'sd16384;
    else if (v < -36'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic signed [18:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } cordic_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/cam_cordic.sv =====
`default_nettype none
module cam_cordic (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cam_pkg::cordic_req_t req,
  output cam_pkg::cordic_rsp_t   rsp
);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [27:0] z_r, z_nxt;
  logic [cam_pkg::IterW-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, flip_r, flip_nxt, done_r, done_nxt;
  logic signed [18:0] a_adj;
  logic flip_c;
  logic signed [35:0] xr, yr;
  logic signed [33:0] xf, yf;

  always_comb begin
    flip_c = 1'b0;
    a_adj = req.angle;
    if (req.angle > cam_pkg::QuarterTurn) begin
      a_adj = req.angle - cam_pkg::YawHalf;
      flip_c = 1'b1;
    end else if (req.angle < -cam_pkg::QuarterTurn) begin
      a_adj = req.angle + cam_pkg::YawHalf;
      flip_c = 1'b1;
    end
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    if (req.start) begin
      x_nxt = cam_pkg::CordicGainQ30;
      y_nxt = '0;
      z_nxt = {a_adj[18], a_adj[18:0], 8'd0};
      i_nxt = '0;
      busy_nxt = 1'b1;
      flip_nxt = flip_c;
    end else if (busy_r) begin
      if (!z_r[27]) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - cam_pkg::atan_lookup(i_r);
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + cam_pkg::atan_lookup(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == cam_pkg::IterW'(cam_pkg::CordicIters - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    flip_r <= flip_nxt;
  end

  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xr = (36'(xf) + 36'sd32768) >>> 16;
    yr = (36'(yf) + 36'sd32768) >>> 16;
    rsp.done = done_r;
    rsp.cos_v = cam_pkg::sat14(xr);
    rsp.sin_v = cam_pkg::sat14(yr);
  end

endmodule
`default_nettype wire

// ===== rtl/camera_orientation_and_move_core.sv =====
`default_nettype none
// Fly-camera orientation and move unit.
// Input channel (in_valid/in_stall) takes one request: pan_yaw, pan_pitch and
// the move vector move_fwd/move_up/move_side. The result channel
// (out_valid/out_stall) returns the new position, yaw, pitch and look vector.
// The up vector lives in three APB registers at byte addresses 0, 4 and 8.
// One shared CORDIC unit runs 16 iterations for yaw, then for pitch, and one
// shared 18x16 multiplier with an accumulator then builds the look vector,
// the right vector and the displacement, one product per cycle.
// A request passes through two CORDIC passes, each of one load, 16 iterations
// and one done step, then through 17 multiplier steps before its result is
// valid. The block takes one request at a time, so a new request is not
// accepted before the last result has gone; in_stall is high from the cycle
// after acceptance until the result register has been emptied.
// While the receiver holds out_stall the result stays in its register and no
// new request is taken. Reset clears the angles and position to zero and sets
// the up vector to (0, 1, 0).
module camera_orientation_and_move_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [16:0] in_pan_yaw,
  input  wire logic signed [16:0] in_pan_pitch,
  input  wire logic signed [15:0] in_move_fwd,
  input  wire logic signed [15:0] in_move_up,
  input  wire logic signed [15:0] in_move_side,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [16:0]      out_yaw_out,
  output logic signed [15:0]      out_pitch_out,
  output logic signed [15:0]      out_look_x,
  output logic signed [15:0]      out_look_y,
  output logic signed [15:0]      out_look_z,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CY   = 3'd1;
  localparam logic [2:0] S_CP   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] RegUpX = 2'd0;
  localparam logic [1:0] RegUpY = 2'd1;
  localparam logic [1:0] RegUpZ = 2'd2;

  logic [2:0] st_r, st_nxt;
  logic [4:0] step_r, step_nxt;
  logic signed [15:0] up_r [3];
  logic signed [16:0] yaw_r, yaw_nxt;
  logic signed [15:0] pitch_r, pitch_nxt;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] mv_r [3];
  logic signed [15:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [15:0] look_r [3];
  logic signed [17:0] right_r [3];
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [17:0] ma;
  logic signed [15:0] mb;
  logic signed [33:0] prod;
  logic clr, sub;
  logic out_valid_r;
  cam_pkg::cordic_req_t creq;
  cam_pkg::cordic_rsp_t crsp;
  logic cfg_wr;
  logic in_acc;
  logic signed [18:0] tyaw, ny;
  logic signed [17:0] tp;
  logic signed [18:0] dy;
  logic signed [17:0] dp;
  logic signed [47:0] r14, r6;

  cam_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_stall = (st_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    unique case (paddr[3:2])
      RegUpX: prdata = 32'(up_r[0]);
      RegUpY: prdata = 32'(up_r[1]);
      RegUpZ: prdata = 32'(up_r[2]);
      default: prdata = '0;
    endcase
  end

  // Angle update for an accepted request.
  always_comb begin
    tyaw = 19'(yaw_r) + 19'(in_pan_yaw);
    dy = tyaw - 19'(yaw_r);
    ny = 19'(yaw_r) + (dy >>> 2);
    if (ny >= cam_pkg::YawHalf) ny = ny - 19'(2 * cam_pkg::YawHalf);
    else if (ny < -cam_pkg::YawHalf) ny = ny + 19'(2 * cam_pkg::YawHalf);
    yaw_nxt = ny[16:0];
    tp = 18'(pitch_r) + 18'(in_pan_pitch);
    if (tp > cam_pkg::PitchLimit) tp = cam_pkg::PitchLimit;
    if (tp < -cam_pkg::PitchLimit) tp = -cam_pkg::PitchLimit;
    dp = tp - 18'(pitch_r);
    pitch_nxt = 16'(18'(pitch_r) + (dp >>> 2));
  end

  // Multiplier schedule: steps 0..1 look x/z, 2..7 right, 8..16 displacement.
  always_comb begin
    ma = '0; mb = '0; clr = 1'b0; sub = 1'b0;
    unique case (step_r)
      5'd0: begin ma = 18'(cp_r); mb = cy_r; clr = 1'b1; end
      5'd1: begin ma = 18'(cp_r); mb = sy_r; clr = 1'b1; end
      5'd2: begin ma = 18'(look_r[1]); mb = up_r[2]; clr = 1'b1; end
      5'd3: begin ma = 18'(look_r[2]); mb = up_r[1]; sub = 1'b1; end
      5'd4: begin ma = 18'(look_r[2]); mb = up_r[0]; clr = 1'b1; end
      5'd5: begin ma = 18'(look_r[0]); mb = up_r[2]; sub = 1'b1; end
      5'd6: begin ma = 18'(look_r[0]); mb = up_r[1]; clr = 1'b1; end
      5'd7: begin ma = 18'(look_r[1]); mb = up_r[0]; sub = 1'b1; end
      5'd8:  begin ma = 18'(look_r[0]); mb = mv_r[0]; clr = 1'b1; end
      5'd9:  begin ma = 18'(up_r[0]); mb = mv_r[1]; end
      5'd10: begin ma = right_r[0]; mb = mv_r[2]; end
      5'd11: begin ma = 18'(look_r[1]); mb = mv_r[0]; clr = 1'b1; end
      5'd12: begin ma = 18'(up_r[1]); mb = mv_r[1]; end
      5'd13: begin ma = right_r[1]; mb = mv_r[2]; end
      5'd14: begin ma = 18'(look_r[2]); mb = mv_r[0]; clr = 1'b1; end
      5'd15: begin ma = 18'(up_r[2]); mb = mv_r[1]; end
      5'd16: begin ma = right_r[2]; mb = mv_r[2]; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
    if (clr) acc_nxt = 48'(prod);
    else if (sub) acc_nxt = acc_r - 48'(prod);
    else acc_nxt = acc_r + 48'(prod);
    r14 = (acc_nxt + 48'sd8192) >>> 14;
    r6 = (acc_nxt + 48'sd32) >>> 6;
  end

  always_comb begin
    st_nxt = st_r;
    step_nxt = step_r;
    creq.start = 1'b0;
    creq.angle = 19'(yaw_nxt);
    unique case (st_r)
      S_IDLE: if (in_acc) begin
        st_nxt = S_CY;
        creq.start = 1'b1;
      end
      S_CY: if (crsp.done) begin
        st_nxt = S_CP;
        creq.start = 1'b1;
        creq.angle = 19'(pitch_r);
      end
      S_CP: if (crsp.done) begin
        st_nxt = S_MUL;
        step_nxt = '0;
      end
      S_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd16) st_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      step_r <= '0;
      up_r[0] <= 16'sd0;
      up_r[1] <= 16'sd16384;
      up_r[2] <= 16'sd0;
      yaw_r <= '0;
      pitch_r <= '0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      step_r <= step_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          RegUpX: up_r[0] <= pwdata[15:0];
          RegUpY: up_r[1] <= pwdata[15:0];
          RegUpZ: up_r[2] <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        yaw_r <= yaw_nxt;
        pitch_r <= pitch_nxt;
      end
      if (st_r == S_MUL) begin
        unique case (step_r)
          5'd10: pos_r[0] <= pos_r[0] + r6[31:0];
          5'd13: pos_r[1] <= pos_r[1] + r6[31:0];
          5'd16: pos_r[2] <= pos_r[2] + r6[31:0];
          default: ;
        endcase
      end
      if (st_r == S_MUL && step_r == 5'd16) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      mv_r[0] <= in_move_fwd;
      mv_r[1] <= in_move_up;
      mv_r[2] <= in_move_side;
    end
    if (st_r == S_CY && crsp.done) begin
      cy_r <= crsp.cos_v;
      sy_r <= crsp.sin_v;
    end
    if (st_r == S_CP && crsp.done) begin
      cp_r <= crsp.cos_v;
      sp_r <= crsp.sin_v;
      look_r[1] <= crsp.sin_v;
    end
    acc_r <= acc_nxt;
    if (st_r == S_MUL) begin
      unique case (step_r)
        5'd0: look_r[0] <= cam_pkg::sat14(r14[35:0]);
        5'd1: look_r[2] <= cam_pkg::sat14(r14[35:0]);
        5'd3: right_r[0] <= r14[17:0];
        5'd5: right_r[1] <= r14[17:0];
        5'd7: right_r[2] <= r14[17:0];
        default: ;
      endcase
    end
  end

  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_yaw_out = yaw_r;
  assign out_pitch_out = pitch_r;
  assign out_look_x = look_r[0];
  assign out_look_y = look_r[1];
  assign out_look_z = look_r[2];

endmodule
`default_nettype wire
